[sv/bfa_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bfa_pkg
// shared types and constants for the best fit block allocator
// ----------------------------------------------------------------------------
package bfa_pkg;

  localparam int unsigned SLOTS_DEF   = 129;
  localparam int unsigned GRANULE_DEF = 64;
  localparam int unsigned BANK_DEF    = 131072;
  localparam int unsigned ADDR_W      = 21;
  localparam int unsigned LEN_W       = 22;
  localparam int unsigned AGE_W       = 32;
  localparam int unsigned EXT_W       = 23;

  localparam logic [ADDR_W-1:0] HEAP_BASE_RST = 21'h005040;
  localparam logic [LEN_W-1:0]  HEAP_LEN_RST  = 22'h1FAFBF;
  localparam logic [LEN_W-1:0]  LEN_MAX       = 22'h3FFFFF;

  localparam logic CFG_HEAP_BASE = 1'b0;
  localparam logic CFG_HEAP_LEN  = 1'b1;

  typedef enum logic [2:0] {
    OP_ALLOC = 3'd0,
    OP_RALLOC = 3'd1,
    OP_FREE = 3'd2,
    OP_MARK = 3'd3,
    OP_INIT = 3'd4,
    OP_QUERY = 3'd5,
    OP_RSV6 = 3'd6,
    OP_RSV7 = 3'd7
  } op_e;

  typedef enum logic [2:0] {
    ST_OK = 3'd0,
    ST_ZERO = 3'd1,
    ST_NOFIT = 3'd2,
    ST_NOSLOT = 3'd3,
    ST_NOTFREE = 3'd4
  } status_e;

  typedef enum logic [3:0] {
    S_IDLE,
    S_CLEAR,
    S_SCAN_RD,
    S_SCAN,
    S_DECIDE,
    S_WRITE,
    S_WRITE2,
    S_STAT_RD,
    S_STAT,
    S_DONE
  } state_e;

  // one free table entry
  typedef struct packed {
    logic              valid;
    logic [ADDR_W-1:0] start;
    logic [LEN_W-1:0]  len;
    logic [AGE_W-1:0]  age;
  } slot_t;

endpackage

`default_nettype wire

[sv/bfa_table.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bfa_table
// free extent table: one write port, one registered read port
// ----------------------------------------------------------------------------
module bfa_table #(
  parameter int unsigned SLOTS = bfa_pkg::SLOTS_DEF,
  parameter int unsigned IDX_W = $clog2(SLOTS)
) (
  input  wire logic                  clk_i,
  input  wire logic                  we_i,
  input  wire logic [IDX_W-1:0]      waddr_i,
  input  wire bfa_pkg::slot_t        wdata_i,
  input  wire logic [IDX_W-1:0]      raddr_i,
  output bfa_pkg::slot_t             rdata_o
);

  bfa_pkg::slot_t mem_q [SLOTS];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

`default_nettype wire

[sv/best_fit_block_allocator_top.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// best_fit_block_allocator_top
// free extent allocator with best fit, bank aligned reverse alloc and merge
// ----------------------------------------------------------------------------
// passes: query and rejected words run the statistics pass only; alloc, free,
//   mark and init add a scan pass and the table writes; reverse alloc adds a
//   second pass for the holding extent and a spare slot
// throughput: one word at a time, next word taken once the result is accepted
// reset: a clearing pass over every entry runs after reset; no word is taken
//   until it ends, configuration writes are accepted throughout
// ----------------------------------------------------------------------------
module best_fit_block_allocator_top #(
  parameter int unsigned SLOTS   = bfa_pkg::SLOTS_DEF,
  parameter int unsigned GRANULE = bfa_pkg::GRANULE_DEF,
  parameter int unsigned BANK    = bfa_pkg::BANK_DEF
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        in_valid_i,
  output logic             in_stall_o,
  input  wire logic [2:0]  op_i,
  input  wire logic [20:0] addr_i,
  input  wire logic [21:0] length_i,
  output logic             out_valid_o,
  input  wire logic        out_stall_i,
  output logic [20:0]      block_addr_o,
  output logic [2:0]       status_o,
  output logic [21:0]      free_total_o,
  output logic [21:0]      largest_free_o,
  input  wire logic        cfg_valid_i,
  output logic             cfg_ready_o,
  input  wire logic        cfg_index_i,
  input  wire logic [21:0] cfg_data_i
);

  localparam int unsigned IDX_W = $clog2(SLOTS);
  localparam int unsigned CNT_W = $clog2(SLOTS + 1);
  localparam int unsigned AW = bfa_pkg::ADDR_W;
  localparam int unsigned LW = bfa_pkg::LEN_W;
  localparam int unsigned XW = bfa_pkg::EXT_W;
  localparam logic [XW-1:0] GMASK = XW'(GRANULE - 1);
  localparam logic [XW-1:0] BMASK = XW'(BANK - 1);
  localparam logic [XW-1:0] SPACE = XW'(64'd1 << AW);
  localparam logic [CNT_W-1:0] LAST = CNT_W'(SLOTS - 1);
  localparam logic [CNT_W-1:0] NONE = CNT_W'(SLOTS);

  // scan pass kinds
  localparam logic [2:0] P_BEST  = 3'd0;
  localparam logic [2:0] P_RBEST = 3'd1;
  localparam logic [2:0] P_MARK  = 3'd2;
  localparam logic [2:0] P_FREE  = 3'd3;
  localparam logic [2:0] P_NONE  = 3'd4;

  bfa_pkg::state_e state_q, state_d;

  logic [AW-1:0] base_q;
  logic [LW-1:0] hlen_q;
  logic [2:0]    op_q;
  logic [2:0]    pass_q, pass_d;
  logic [XW-1:0] loc_q, loc_d;
  logic [XW-1:0] size_q, size_d;
  logic [CNT_W-1:0] cnt_q;
  logic [CNT_W-1:0] rcnt_q;
  logic [CNT_W-1:0] best_q, pick_q, spare_q;
  logic [XW-1:0] best_len_q, best_start_q;
  logic [31:0]   best_age_q;
  logic [31:0]   ictr_q;
  logic [2:0]    st_q;
  logic [AW-1:0] where_q;
  logic [LW-1:0] tot_q, big_q;
  logic          rd_valid_q;

  logic          we;
  logic [IDX_W-1:0] waddr;
  bfa_pkg::slot_t wdata, rdata;
  logic [IDX_W-1:0] raddr;

  // decide step: plan up to two writes
  logic          w1_en, w2_en, w1_put;
  logic [CNT_W-1:0] w1_idx, w2_idx;
  logic [XW-1:0] w1_s, w1_l, w2_s, w2_l;
  logic [2:0]    dec_st;
  logic [AW-1:0] dec_where;
  logic          go_mark;

  // registered write plan
  logic          w1_en_q, w2_en_q, w1_put_q;
  logic [CNT_W-1:0] w1_idx_q, w2_idx_q;
  logic [XW-1:0] w1_s_q, w1_l_q, w2_s_q, w2_l_q;

  bfa_table #(.SLOTS(SLOTS), .IDX_W(IDX_W)) u_table (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (waddr),
    .wdata_i (wdata),
    .raddr_i (raddr),
    .rdata_o (rdata)
  );

  assign cfg_ready_o = 1'b1;
  assign in_stall_o = (state_q != bfa_pkg::S_IDLE);

  logic in_acc;
  assign in_acc = in_valid_i && !in_stall_o;

  // rounded request length
  logic [XW-1:0] rlen, init_len, init_lim;
  assign rlen = (XW'(length_i) + GMASK) & ~GMASK;
  assign init_len = (XW'(hlen_q) + GMASK) & ~GMASK;
  assign init_lim = (SPACE - XW'(base_q)) & ~GMASK;

  // entry being examined
  logic [XW-1:0] e_start, e_len, e_end, e_bound;
  logic          e_v;
  assign e_v = rd_valid_q && rdata.valid;
  assign e_start = XW'(rdata.start);
  assign e_len = XW'(rdata.len);
  assign e_end = e_start + e_len;
  assign e_bound = e_end & ~BMASK;

  // init sees the table as empty and clears every entry it passes
  logic f_v;
  assign f_v = e_v && (op_q != bfa_pkg::OP_INIT);

  logic scan_fin;
  assign scan_fin = rd_valid_q && (rcnt_q == LAST);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      base_q <= bfa_pkg::HEAP_BASE_RST;
      hlen_q <= bfa_pkg::HEAP_LEN_RST;
    end else if (cfg_valid_i) begin
      if (cfg_index_i == bfa_pkg::CFG_HEAP_BASE) base_q <= cfg_data_i[AW-1:0];
      else hlen_q <= cfg_data_i;
    end
  end

  // read address runs with cnt_q during scans
  assign raddr = cnt_q[IDX_W-1:0];

  logic rd_go;
  assign rd_go = (cnt_q != NONE) &&
                 ((state_q == bfa_pkg::S_SCAN_RD && pass_q != P_NONE) ||
                  state_q == bfa_pkg::S_STAT_RD || state_q == bfa_pkg::S_SCAN ||
                  state_q == bfa_pkg::S_STAT);

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      bfa_pkg::S_IDLE:    if (in_acc) state_d = bfa_pkg::S_SCAN_RD;
      bfa_pkg::S_CLEAR:   if (cnt_q == LAST) state_d = bfa_pkg::S_IDLE;
      bfa_pkg::S_SCAN_RD: state_d = (pass_q == P_NONE) ? bfa_pkg::S_STAT_RD
                                                        : bfa_pkg::S_SCAN;
      bfa_pkg::S_SCAN:    if (scan_fin) state_d = bfa_pkg::S_DECIDE;
      bfa_pkg::S_DECIDE:  state_d = go_mark ? bfa_pkg::S_SCAN_RD : bfa_pkg::S_WRITE;
      bfa_pkg::S_WRITE:   state_d = bfa_pkg::S_WRITE2;
      bfa_pkg::S_WRITE2:  state_d = bfa_pkg::S_STAT_RD;
      bfa_pkg::S_STAT_RD: state_d = bfa_pkg::S_STAT;
      bfa_pkg::S_STAT:    if (scan_fin) state_d = bfa_pkg::S_DONE;
      bfa_pkg::S_DONE:    if (!out_stall_i) state_d = bfa_pkg::S_IDLE;
      default:            state_d = bfa_pkg::S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= bfa_pkg::S_CLEAR;
      cnt_q <= '0;
      rcnt_q <= '0;
      rd_valid_q <= 1'b0;
      ictr_q <= '0;
      pass_q <= P_NONE;
      op_q <= '0;
    end else begin
      state_q <= state_d;
      rd_valid_q <= rd_go;
      if (rd_go) rcnt_q <= cnt_q;
      if (state_q == bfa_pkg::S_CLEAR || rd_go) cnt_q <= cnt_q + 1'b1;
      else if ((state_q == bfa_pkg::S_IDLE && in_acc) || state_q == bfa_pkg::S_DECIDE)
        cnt_q <= '0;
      if (state_q == bfa_pkg::S_IDLE && in_acc) begin
        op_q <= op_i;
        pass_q <= pass_d;
      end else if (state_q == bfa_pkg::S_DECIDE && go_mark) begin
        pass_q <= P_MARK;
      end
      if ((state_q == bfa_pkg::S_WRITE && w1_en_q && w1_put_q) ||
          (state_q == bfa_pkg::S_WRITE2 && w2_en_q))
        ictr_q <= ictr_q + 1'b1;
    end
  end

  // pass selection at accept
  logic zero_req;
  always_comb begin
    loc_d = XW'(addr_i);
    size_d = rlen;
    zero_req = (length_i == '0);
    pass_d = P_NONE;
    unique case (op_i)
      bfa_pkg::OP_ALLOC:  pass_d = zero_req ? P_NONE : P_BEST;
      bfa_pkg::OP_RALLOC: pass_d = zero_req ? P_NONE : P_RBEST;
      bfa_pkg::OP_FREE:
        pass_d = (zero_req || (XW'(addr_i) + rlen > SPACE)) ? P_NONE : P_FREE;
      bfa_pkg::OP_MARK:   pass_d = zero_req ? P_NONE : P_MARK;
      bfa_pkg::OP_INIT: begin
        loc_d = XW'(base_q);
        size_d = (XW'(base_q) + init_len > SPACE) ? init_lim : init_len;
        pass_d = P_FREE;
      end
      default: pass_d = P_NONE;
    endcase
  end

  // scan accumulation
  logic        mk_hit_q;
  logic [XW-1:0] mk_s_q, mk_end_q;
  always_ff @(posedge clk_i) begin
    if (state_q == bfa_pkg::S_IDLE && in_acc) begin
      loc_q <= loc_d;
      size_q <= size_d;
      best_q <= NONE;
      pick_q <= NONE;
      spare_q <= NONE;
      mk_hit_q <= 1'b0;
      if (zero_req && op_i != bfa_pkg::OP_INIT && op_i != bfa_pkg::OP_QUERY &&
          op_i != bfa_pkg::OP_RSV6 && op_i != bfa_pkg::OP_RSV7)
        st_q <= bfa_pkg::ST_ZERO;
      else if (op_i == bfa_pkg::OP_INIT && size_d == '0) st_q <= bfa_pkg::ST_ZERO;
      else if (op_i == bfa_pkg::OP_FREE && pass_d == P_NONE)
        st_q <= bfa_pkg::ST_NOTFREE;
      else st_q <= bfa_pkg::ST_OK;
      where_q <= '0;
    end
    if (state_q == bfa_pkg::S_DECIDE) begin
      st_q <= dec_st;
      where_q <= dec_where;
      if (go_mark) begin
        loc_q <= best_start_q;
        mk_hit_q <= 1'b0;
        spare_q <= NONE;
      end
    end
    if (state_q == bfa_pkg::S_SCAN && rd_valid_q) begin
      unique case (pass_q)
        P_BEST: begin
          if (e_v && e_len >= size_q &&
              (best_q == NONE || e_len < best_len_q ||
               (e_len == best_len_q && rdata.age < best_age_q))) begin
            best_q <= rcnt_q;
            best_len_q <= e_len;
            best_start_q <= e_start;
            best_age_q <= rdata.age;
          end
        end
        P_RBEST: begin
          if (e_v && e_len >= size_q && e_bound > e_start &&
              e_bound - e_start >= size_q &&
              (best_q == NONE || e_len < best_len_q)) begin
            best_q <= rcnt_q;
            best_len_q <= e_len;
            best_start_q <= e_bound - size_q;
          end
        end
        P_MARK: begin
          if (e_v && !mk_hit_q && loc_q >= e_start && loc_q < e_end) begin
            mk_hit_q <= 1'b1;
            best_q <= rcnt_q;
            mk_s_q <= e_start;
            mk_end_q <= e_end;
          end
          if (!e_v && spare_q == NONE && !(e_v && !mk_hit_q &&
              loc_q >= e_start && loc_q < e_end))
            spare_q <= rcnt_q;
        end
        P_FREE: begin
          if (f_v && e_end == loc_q) begin
            size_q <= size_q + e_len;
            loc_q <= e_start;
            if (rcnt_q < pick_q) pick_q <= rcnt_q;
          end else if (f_v && e_start == loc_q + size_q) begin
            size_q <= size_q + e_len;
            if (rcnt_q < pick_q) pick_q <= rcnt_q;
          end else if (!f_v && rcnt_q < pick_q) begin
            pick_q <= rcnt_q;
          end
        end
        default: ;
      endcase
    end
  end

  // merged neighbours are invalidated during the free scan
  logic f_kill;
  assign f_kill = (state_q == bfa_pkg::S_SCAN) && rd_valid_q && pass_q == P_FREE &&
                  ((op_q == bfa_pkg::OP_INIT) ||
                   (f_v && (e_end == loc_q || e_start == loc_q + size_q)));

  // decide
  always_comb begin
    w1_en = 1'b0; w1_put = 1'b0; w1_idx = best_q; w1_s = '0; w1_l = '0;
    w2_en = 1'b0; w2_idx = spare_q; w2_s = '0; w2_l = '0;
    dec_st = st_q; dec_where = '0; go_mark = 1'b0;
    unique case (pass_q)
      P_BEST: begin
        if (best_q == NONE) dec_st = bfa_pkg::ST_NOFIT;
        else begin
          dec_st = bfa_pkg::ST_OK;
          dec_where = best_start_q[AW-1:0];
          w1_en = 1'b1;
          w1_put = (best_len_q != size_q);
          w1_s = best_start_q + size_q;
          w1_l = best_len_q - size_q;
        end
      end
      P_RBEST: begin
        if (best_q == NONE) dec_st = bfa_pkg::ST_NOFIT;
        else go_mark = 1'b1;
      end
      P_MARK: begin
        if (!mk_hit_q || loc_q + size_q > mk_end_q) dec_st = bfa_pkg::ST_NOTFREE;
        else if (loc_q == mk_s_q) begin
          dec_st = bfa_pkg::ST_OK; dec_where = loc_q[AW-1:0];
          w1_en = 1'b1; w1_put = (mk_end_q != loc_q + size_q);
          w1_s = loc_q + size_q; w1_l = mk_end_q - loc_q - size_q;
        end else if (loc_q + size_q == mk_end_q) begin
          dec_st = bfa_pkg::ST_OK; dec_where = loc_q[AW-1:0];
          w1_en = 1'b1; w1_put = 1'b1; w1_s = mk_s_q; w1_l = loc_q - mk_s_q;
        end else if (spare_q == NONE) dec_st = bfa_pkg::ST_NOSLOT;
        else begin
          dec_st = bfa_pkg::ST_OK; dec_where = loc_q[AW-1:0];
          w1_en = 1'b1; w1_put = 1'b1; w1_s = mk_s_q; w1_l = loc_q - mk_s_q;
          w2_en = 1'b1; w2_s = loc_q + size_q; w2_l = mk_end_q - loc_q - size_q;
        end
      end
      P_FREE: begin
        if (st_q != bfa_pkg::ST_OK) dec_st = st_q;
        else if (pick_q == NONE) dec_st = bfa_pkg::ST_NOSLOT;
        else begin
          dec_st = bfa_pkg::ST_OK;
          w1_en = 1'b1; w1_put = 1'b1; w1_idx = pick_q; w1_s = loc_q; w1_l = size_q;
        end
      end
      default: ;
    endcase
    if (op_q != bfa_pkg::OP_MARK && op_q != bfa_pkg::OP_ALLOC &&
        op_q != bfa_pkg::OP_RALLOC) dec_where = '0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      w1_en_q <= 1'b0;
      w2_en_q <= 1'b0;
    end else if (state_q == bfa_pkg::S_DECIDE) begin
      w1_en_q <= w1_en && !go_mark;
      w2_en_q <= w2_en && !go_mark;
    end else if (state_q == bfa_pkg::S_WRITE2) begin
      w1_en_q <= 1'b0;
      w2_en_q <= 1'b0;
    end
  end
  always_ff @(posedge clk_i) begin
    if (state_q == bfa_pkg::S_DECIDE) begin
      w1_put_q <= w1_put; w1_idx_q <= w1_idx; w1_s_q <= w1_s; w1_l_q <= w1_l;
      w2_idx_q <= w2_idx; w2_s_q <= w2_s; w2_l_q <= w2_l;
    end
  end

  // table writes: clear, free merge kill, plan writes
  always_comb begin
    we = 1'b0;
    waddr = rcnt_q[IDX_W-1:0];
    wdata = '0;
    if (state_q == bfa_pkg::S_CLEAR) begin
      we = 1'b1;
      waddr = cnt_q[IDX_W-1:0];
    end else if (f_kill) begin
      we = 1'b1;
    end else if (state_q == bfa_pkg::S_WRITE && w1_en_q) begin
      we = 1'b1;
      waddr = w1_idx_q[IDX_W-1:0];
      wdata.valid = w1_put_q;
      wdata.start = w1_s_q[AW-1:0];
      wdata.len = w1_l_q[LW-1:0];
      wdata.age = ictr_q;
    end else if (state_q == bfa_pkg::S_WRITE2 && w2_en_q) begin
      we = 1'b1;
      waddr = w2_idx_q[IDX_W-1:0];
      wdata.valid = 1'b1;
      wdata.start = w2_s_q[AW-1:0];
      wdata.len = w2_l_q[LW-1:0];
      wdata.age = ictr_q;
    end
  end

  // statistics pass
  logic [XW-1:0] tsum;
  assign tsum = XW'(tot_q) + e_len;
  always_ff @(posedge clk_i) begin
    if (state_q == bfa_pkg::S_STAT_RD) begin
      tot_q <= '0;
      big_q <= '0;
    end else if (state_q == bfa_pkg::S_STAT && e_v) begin
      tot_q <= tsum[LW] ? bfa_pkg::LEN_MAX : tsum[LW-1:0];
      if (rdata.len > big_q) big_q <= rdata.len;
    end
  end

  // result word
  always_comb begin
    out_valid_o = (state_q == bfa_pkg::S_DONE);
    block_addr_o = (st_q == bfa_pkg::ST_OK) ? where_q : '0;
    status_o = st_q;
    free_total_o = tot_q;
    largest_free_o = big_q;
  end

  property p_out_hold;
    @(posedge clk_i) disable iff (!rst_ni)
      out_valid_o && out_stall_i |=> out_valid_o && $stable(block_addr_o) &&
        $stable(status_o) && $stable(free_total_o) && $stable(largest_free_o);
  endproperty
  a_out_hold: assert property (p_out_hold);

  a_busy_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> in_stall_o);

  a_status_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> status_o <= 3'(bfa_pkg::ST_NOTFREE));

endmodule

`default_nettype wire
